// ===== rtl/core/lss_pkg.sv =====
// Package: shared types, codes and constants of the link session supervisor.
package lss_pkg;

  // Ping echo limit and the largest length the 6-bit pong field can carry
  localparam int unsigned PAYLOAD_LIMIT = 32;
  localparam logic [5:0] PONG_MAX = 6'((PAYLOAD_LIMIT > 63) ? 63 : PAYLOAD_LIMIT);

  // Register reset values
  localparam logic [7:0]  INVALID_LIMIT_RST = 8'd3;
  localparam logic [15:0] HB_PERIOD_RST     = 16'd1000;
  localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd5000;

  // Configuration address width and register indexes
  localparam int unsigned PADDR_W = 4;
  typedef enum logic [1:0] {
    REG_INVALID_LIMIT = 2'd0,
    REG_HB_PERIOD     = 2'd1,
    REG_IDLE_TIMEOUT  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_PACKET  = 2'd1,
    ACT_INVALID = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_PING  = 3'd2,
    KIND_RESET = 3'd3
  } kind_e;

  typedef enum logic [2:0] {
    TR_NONE      = 3'd0,
    TR_START     = 3'd1,
    TR_STOP      = 3'd2,
    TR_TIMEOUT   = 3'd3,
    TR_TO_ERROR  = 3'd4,
    TR_RESET     = 3'd5
  } trans_e;

  // Mode as reported on the result channel
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_e;

  // Session state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LIVE  = 3'b010,
    ST_FAULT = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0]  invalid_limit;
    logic [15:0] heartbeat_period_ms;
    logic [15:0] idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_ms;
    logic [2:0]  packet_kind;
    logic [7:0]  payload_length;
    logic [7:0]  invalid_run;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  transition;
    logic        heartbeat;
    logic [31:0] heartbeat_elapsed_ms;
    logic        pong;
    logic [5:0]  pong_length;
    logic        unknown_kind;
    logic [31:0] next_deadline_ms;
  } result_t;

  function automatic mode_e mode_code(input state_e st);
    mode_e code;
    case (st)
      ST_LIVE:  code = MODE_ACTIVE;
      ST_FAULT: code = MODE_ERROR;
      default:  code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/lss_if.sv =====
// Interfaces: event item channel and result channel of the session supervisor.
interface lss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] time_ms;
  logic [2:0]  packet_kind;
  logic [7:0]  payload_length;
  logic [7:0]  invalid_run;

  modport source (output valid, action, time_ms, packet_kind, payload_length, invalid_run,
                  input ready);
  modport sink (input valid, action, time_ms, packet_kind, payload_length, invalid_run,
                output ready);
endinterface

interface lss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  transition;
  logic        heartbeat;
  logic [31:0] heartbeat_elapsed_ms;
  logic        pong;
  logic [5:0]  pong_length;
  logic        unknown_kind;
  logic [31:0] next_deadline_ms;

  modport source (output valid, mode, transition, heartbeat, heartbeat_elapsed_ms, pong,
                  pong_length, unknown_kind, next_deadline_ms, input ready);
  modport sink (input valid, mode, transition, heartbeat, heartbeat_elapsed_ms, pong,
                pong_length, unknown_kind, next_deadline_ms, output ready);
endinterface

// ===== rtl/core/link_session_supervisor_core.sv =====
// Top level: link session supervisor with input register, update logic and result register.
// Each transfer on in_i (a time tick, a received packet or an invalid-frame report) gives
// exactly one transfer on out_o, registered in the input register and then the result
// register, and one item is taken every clock cycle while out_o is not stalled. The rate
// is set by the session state loop: mode and the four time registers are read and
// rewritten while an item is in the update stage, through one 32x32 reciprocal multiply
// for the 1000 ms rounding and one add-and-compare for the next deadline. A stalled
// output holds its result while one more item waits in the input register. Configuration
// writes take effect for the next item and should be issued only while no item is in flight.
module link_session_supervisor_core
  import lss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  lss_in_if.sink             in_i,
  lss_out_if.source          out_o
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  result_t res;
  result_t out_q;
  logic    out_vld_q;
  logic    advance;
  logic    step_en;

  lss_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move forward whenever the result register is free or being drained
  assign advance    = ~out_vld_q | out_o.ready;
  assign step_en    = in_vld_q & advance;
  assign in_i.ready = ~in_vld_q | advance;

  // Capture the incoming transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.action         <= in_i.action;
      in_q.time_ms        <= in_i.time_ms;
      in_q.packet_kind    <= in_i.packet_kind;
      in_q.payload_length <= in_i.payload_length;
      in_q.invalid_run    <= in_i.invalid_run;
    end
  end

  lss_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res;
    end
  end

  assign out_o.valid                = out_vld_q;
  assign out_o.mode                 = out_q.mode;
  assign out_o.transition           = out_q.transition;
  assign out_o.heartbeat            = out_q.heartbeat;
  assign out_o.heartbeat_elapsed_ms = out_q.heartbeat_elapsed_ms;
  assign out_o.pong                 = out_q.pong;
  assign out_o.pong_length          = out_q.pong_length;
  assign out_o.unknown_kind         = out_q.unknown_kind;
  assign out_o.next_deadline_ms     = out_q.next_deadline_ms;

  // An item waiting behind a stalled result is never dropped
  a_hold_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_q))
    else $error("queued item lost while output stalled");

  // A deadline is reported only for an active session
  a_deadline_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.mode != MODE_ACTIVE |-> out_q.next_deadline_ms == 32'd0)
    else $error("deadline reported outside active mode");

  // Transition codes agree with the reported mode
  a_trans_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.transition == TR_TO_ERROR) |-> out_q.mode == MODE_ERROR)
    else $error("error transition without error mode");

  // Heartbeat and pong come from different item kinds
  a_hb_pong : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.heartbeat && out_q.pong))
    else $error("heartbeat and pong in one result");

endmodule

// ===== rtl/core/lss_cfg_regs.sv =====
// Module: APB-style configuration registers of the session supervisor.
module lss_cfg_regs
  import lss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  // Write the addressed register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invalid_limit       <= INVALID_LIMIT_RST;
      cfg_q.heartbeat_period_ms <= HB_PERIOD_RST;
      cfg_q.idle_timeout_ms     <= IDLE_TIMEOUT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_INVALID_LIMIT: cfg_q.invalid_limit       <= pwdata[7:0];
        REG_HB_PERIOD:     cfg_q.heartbeat_period_ms <= pwdata[15:0];
        REG_IDLE_TIMEOUT:  cfg_q.idle_timeout_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_INVALID_LIMIT: prdata = {24'd0, cfg_q.invalid_limit};
      REG_HB_PERIOD:     prdata = {16'd0, cfg_q.heartbeat_period_ms};
      REG_IDLE_TIMEOUT:  prdata = {16'd0, cfg_q.idle_timeout_ms};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/lss_ms_round.sv =====
// Module: rounds an elapsed millisecond count down to a multiple of 1000.
module lss_ms_round (
  input  logic [31:0] elapsed_i,
  output logic [31:0] rounded_o
);

  // floor(x / 1000) for any 32-bit x is the high product with 0x10624DD3 shifted by 38
  localparam logic [31:0] RECIP = 32'h10624DD3;

  logic [63:0] prod;
  logic [31:0] quot;

  assign prod = {32'd0, elapsed_i} * {32'd0, RECIP};
  assign quot = {6'd0, prod[63:38]};

  // Multiply back by 1000 = 1024 - 16 - 8
  assign rounded_o = (quot << 10) - (quot << 4) - (quot << 3);

endmodule

// ===== rtl/core/lss_step.sv =====
// Module: session state registers and the per-item update logic.
module lss_step
  import lss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t res_o
);

  state_e      mode_q, mode_d;
  logic [31:0] cur_time_q, cur_time_d;
  logic [31:0] act_start_q, act_start_d;
  logic [31:0] last_cmd_q, last_cmd_d;
  logic [31:0] next_hb_q, next_hb_d;

  logic        active;
  logic [31:0] hb_gap;
  logic [31:0] idle_gap;
  logic [31:0] elapsed;
  logic [31:0] elapsed_rnd;
  logic        hb_hit;
  logic        timeout;
  logic [31:0] idle_due;
  logic [31:0] due_gap;
  logic [5:0]  pong_len;
  trans_e      trans;
  logic        pong;
  logic        unk;

  assign active   = (mode_q == ST_LIVE);
  assign hb_gap   = item_i.time_ms - next_hb_q;
  assign idle_gap = item_i.time_ms - last_cmd_q;
  assign elapsed  = item_i.time_ms - act_start_q;
  assign hb_hit   = active & ~hb_gap[31];
  assign timeout  = active & (idle_gap >= {16'd0, cfg_i.idle_timeout_ms});
  assign pong_len = (item_i.payload_length > {2'd0, PONG_MAX}) ? PONG_MAX
                                                               : item_i.payload_length[5:0];

  lss_ms_round u_round (
    .elapsed_i (elapsed),
    .rounded_o (elapsed_rnd)
  );

  // Next state and result flags for one item
  always_comb begin
    mode_d      = mode_q;
    cur_time_d  = cur_time_q;
    act_start_d = act_start_q;
    last_cmd_d  = last_cmd_q;
    next_hb_d   = next_hb_q;
    trans       = TR_NONE;
    pong        = 1'b0;
    unk         = 1'b0;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        cur_time_d = item_i.time_ms;
        if (hb_hit) begin
          next_hb_d = next_hb_q + {16'd0, cfg_i.heartbeat_period_ms};
        end
        if (timeout) begin
          mode_d = ST_IDLE;
          trans  = TR_TIMEOUT;
        end
      end
      ACT_PACKET: begin
        case (kind_e'(item_i.packet_kind))
          KIND_START: begin
            if (mode_q == ST_IDLE) begin
              mode_d      = ST_LIVE;
              act_start_d = cur_time_q;
              last_cmd_d  = cur_time_q;
              next_hb_d   = cur_time_q + {16'd0, cfg_i.heartbeat_period_ms};
              trans       = TR_START;
            end else if (active) begin
              last_cmd_d = cur_time_q;
            end
          end
          KIND_STOP: begin
            if (active) begin
              mode_d = ST_IDLE;
              trans  = TR_STOP;
            end
          end
          KIND_PING: begin
            if (mode_q != ST_FAULT) begin
              pong       = 1'b1;
              last_cmd_d = cur_time_q;
            end
          end
          KIND_RESET: begin
            if (mode_q == ST_FAULT) begin
              mode_d = ST_IDLE;
              trans  = TR_RESET;
            end
          end
          default: unk = 1'b1;
        endcase
      end
      ACT_INVALID: begin
        if (mode_q != ST_FAULT && item_i.invalid_run >= cfg_i.invalid_limit) begin
          mode_d = ST_FAULT;
          trans  = TR_TO_ERROR;
        end
      end
      default: ;
    endcase
  end

  // Earlier of heartbeat and idle deadline, half-range modular compare
  assign idle_due = last_cmd_d + {16'd0, cfg_i.idle_timeout_ms};
  assign due_gap  = next_hb_d - idle_due;

  always_comb begin
    res_o.mode                 = mode_code(mode_d);
    res_o.transition           = trans;
    res_o.heartbeat            = (action_e'(item_i.action) == ACT_TICK) & hb_hit;
    res_o.heartbeat_elapsed_ms = res_o.heartbeat ? elapsed_rnd : 32'd0;
    res_o.pong                 = pong;
    res_o.pong_length          = pong ? pong_len : 6'd0;
    res_o.unknown_kind         = unk;
    if (mode_d != ST_LIVE) begin
      res_o.next_deadline_ms = 32'd0;
    end else if (!due_gap[31]) begin
      res_o.next_deadline_ms = idle_due;
    end else begin
      res_o.next_deadline_ms = next_hb_d;
    end
  end

  // Commit the update when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ST_IDLE;
      cur_time_q  <= 32'd0;
      act_start_q <= 32'd0;
      last_cmd_q  <= 32'd0;
      next_hb_q   <= 32'd0;
    end else if (en_i) begin
      mode_q      <= mode_d;
      cur_time_q  <= cur_time_d;
      act_start_q <= act_start_d;
      last_cmd_q  <= last_cmd_d;
      next_hb_q   <= next_hb_d;
    end
  end

endmodule

// ===== sim/tb_link_session_supervisor_core.sv =====
// Testbench: link session supervisor core, random and directed traffic checked against a predictor.
`timescale 1ns / 100ps

import lss_pkg::*;

// Track the session state, predict each result and check the results that come out
class session_scoreboard;
  logic [7:0]  invalid_limit;
  logic [15:0] hb_period;
  logic [15:0] idle_timeout;
  mode_e       mode;
  logic [31:0] tick_time;
  logic [31:0] session_start;
  logic [31:0] last_cmd_time;
  logic [31:0] hb_due;
  result_t     expected_q[$];
  int unsigned fail_count;

  function new();
    invalid_limit = INVALID_LIMIT_RST;
    hb_period     = HB_PERIOD_RST;
    idle_timeout  = IDLE_TIMEOUT_RST;
    mode          = MODE_IDLE;
    tick_time     = '0;
    session_start = '0;
    last_cmd_time = '0;
    hb_due        = '0;
    fail_count    = 0;
  endfunction

  function void write_reg(reg_idx_e idx, logic [31:0] value);
    case (idx)
      REG_INVALID_LIMIT: invalid_limit = value[7:0];
      REG_HB_PERIOD:     hb_period = value[15:0];
      REG_IDLE_TIMEOUT:  idle_timeout = value[15:0];
      default: ;
    endcase
  endfunction

  // Half-range modular compare: now_ms is at or past mark_ms
  function bit reached(logic [31:0] now_ms, logic [31:0] mark_ms);
    logic [31:0] diff;
    diff = now_ms - mark_ms;
    return !diff[31];
  endfunction

  // Earlier of the heartbeat time and the inactivity end while active
  function logic [31:0] deadline_ms();
    logic [31:0] idle_end;
    idle_end = last_cmd_time + 32'(idle_timeout);
    if (mode != MODE_ACTIVE) return '0;
    return reached(hb_due, idle_end) ? idle_end : hb_due;
  endfunction

  // Advance the session by one accepted transfer and queue the expected result
  function void note_item(item_t it);
    result_t     r;
    logic [31:0] since;
    r = '0;
    case (it.action)
      ACT_TICK: begin
        tick_time = it.time_ms;
        if (mode == MODE_ACTIVE && reached(it.time_ms, hb_due)) begin
          since = it.time_ms - session_start;
          r.heartbeat = 1'b1;
          // round the elapsed active time down to whole seconds
          r.heartbeat_elapsed_ms = (since / 32'd1000) * 32'd1000;
          hb_due = hb_due + 32'(hb_period);
        end
        since = it.time_ms - last_cmd_time;
        if (mode == MODE_ACTIVE && since >= 32'(idle_timeout)) begin
          mode = MODE_IDLE;
          r.transition = TR_TIMEOUT;
        end
      end
      ACT_PACKET: begin
        case (it.packet_kind)
          KIND_START: begin
            if (mode == MODE_IDLE) begin
              mode          = MODE_ACTIVE;
              session_start = tick_time;
              last_cmd_time = tick_time;
              hb_due        = tick_time + 32'(hb_period);
              r.transition  = TR_START;
            end else if (mode == MODE_ACTIVE) begin
              last_cmd_time = tick_time;
            end
          end
          KIND_STOP: begin
            if (mode == MODE_ACTIVE) begin
              mode = MODE_IDLE;
              r.transition = TR_STOP;
            end
          end
          KIND_PING: begin
            if (mode != MODE_ERROR) begin
              r.pong = 1'b1;
              r.pong_length = (it.payload_length > {2'b00, PONG_MAX}) ?
                              PONG_MAX : it.payload_length[5:0];
              last_cmd_time = tick_time;
            end
          end
          KIND_RESET: begin
            if (mode == MODE_ERROR) begin
              mode = MODE_IDLE;
              r.transition = TR_RESET;
            end
          end
          default: r.unknown_kind = 1'b1;
        endcase
      end
      ACT_INVALID: begin
        if (mode != MODE_ERROR && it.invalid_run >= invalid_limit) begin
          mode = MODE_ERROR;
          r.transition = TR_TO_ERROR;
        end
      end
      default: ;
    endcase
    r.mode = mode;
    r.next_deadline_ms = deadline_ms();
    expected_q.push_back(r);
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Compare one result transfer with the oldest expectation
  task check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing expected");
      return;
    end
    want = expected_q.pop_front();
    compare_field("mode", 32'(got.mode), 32'(want.mode));
    compare_field("transition", 32'(got.transition), 32'(want.transition));
    compare_field("heartbeat", 32'(got.heartbeat), 32'(want.heartbeat));
    compare_field("heartbeat_elapsed_ms", got.heartbeat_elapsed_ms, want.heartbeat_elapsed_ms);
    compare_field("pong", 32'(got.pong), 32'(want.pong));
    compare_field("pong_length", 32'(got.pong_length), 32'(want.pong_length));
    compare_field("unknown_kind", 32'(got.unknown_kind), 32'(want.unknown_kind));
    compare_field("next_deadline_ms", got.next_deadline_ms, want.next_deadline_ms);
  endtask
endclass

module tb_link_session_supervisor_core;

  localparam int unsigned CYCLE_LIMIT       = 200000;
  localparam int unsigned ITEMS_PER_SETTING = 83;
  // action code the block ignores
  localparam logic [1:0]  ACT_NONE          = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lss_in_if  item_if ();
  lss_out_if res_if ();

  session_scoreboard sb;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  int unsigned       cycle_count = 0;
  logic [31:0]       clock_ms;
  item_t             seen_item;
  result_t           seen_res;

  link_session_supervisor_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (item_if),
    .out_o   (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Watch both channels for transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        seen_item.action         = item_if.action;
        seen_item.time_ms        = item_if.time_ms;
        seen_item.packet_kind    = item_if.packet_kind;
        seen_item.payload_length = item_if.payload_length;
        seen_item.invalid_run    = item_if.invalid_run;
        sb.note_item(seen_item);
      end
      if (res_if.valid && res_if.ready) begin
        seen_res.mode                 = res_if.mode;
        seen_res.transition           = res_if.transition;
        seen_res.heartbeat            = res_if.heartbeat;
        seen_res.heartbeat_elapsed_ms = res_if.heartbeat_elapsed_ms;
        seen_res.pong                 = res_if.pong;
        seen_res.pong_length          = res_if.pong_length;
        seen_res.unknown_kind         = res_if.unknown_kind;
        seen_res.next_deadline_ms     = res_if.next_deadline_ms;
        sb.check_result(seen_res);
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    res_if.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic item_t make_item(logic [1:0] act, logic [31:0] t, logic [2:0] kind,
                                      logic [7:0] plen, logic [7:0] run);
    item_t it;
    it.action         = act;
    it.time_ms        = t;
    it.packet_kind    = kind;
    it.payload_length = plen;
    it.invalid_run    = run;
    return it;
  endfunction

  function automatic item_t tick_at(logic [31:0] t);
    return make_item(ACT_TICK, t, 3'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic item_t packet(logic [2:0] kind, logic [7:0] plen);
    return make_item(ACT_PACKET, $urandom, kind, plen, 8'($urandom));
  endfunction

  function automatic item_t invalid_report(logic [7:0] run);
    return make_item(ACT_INVALID, $urandom, 3'($urandom), 8'($urandom), run);
  endfunction

  // Ticks for half the items, walking forward around the period and timeout, plus commands
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned span;
    it = make_item(ACT_TICK, $urandom, 3'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 50) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        span = (sb.hb_period == 0) ? 4 : int'(sb.hb_period);
        clock_ms = clock_ms + $urandom_range(span, 0);
      end else if (pick < 80) begin
        span = int'(sb.idle_timeout);
        clock_ms = clock_ms + $urandom_range(span + span / 4, 0);
      end else if (pick >= 95) begin
        clock_ms = $urandom;
      end
      it.time_ms = clock_ms;
    end else if (pick < 88) begin
      it.action = ACT_PACKET;
      pick = $urandom_range(99);
      if (pick < 28)      it.packet_kind = KIND_START;
      else if (pick < 40) it.packet_kind = KIND_STOP;
      else if (pick < 70) it.packet_kind = KIND_PING;
      else if (pick < 88) it.packet_kind = KIND_RESET;
      else                it.packet_kind = 3'(KIND_RESET) + 3'($urandom_range(4, 1));
      pick = $urandom_range(99);
      if (pick < 30)      it.payload_length = 8'($urandom_range(36, 28));
      else if (pick < 50) it.payload_length = 8'($urandom_range(31, 0));
    end else if (pick < 97) begin
      it.action = ACT_INVALID;
      pick = $urandom_range(99);
      if (pick < 35)      it.invalid_run = sb.invalid_limit;
      else if (pick < 50) it.invalid_run = sb.invalid_limit - 8'd1;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  // Present one item, idling first at random, and hold it until the transfer
  task automatic send_item(item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    item_if.valid          <= 1'b1;
    item_if.action         <= it.action;
    item_if.time_ms        <= it.time_ms;
    item_if.packet_kind    <= it.packet_kind;
    item_if.payload_length <= it.payload_length;
    item_if.invalid_run    <= it.invalid_run;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the data when pready is high
  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic write_all(logic [7:0] lim, logic [15:0] per, logic [15:0] tmo);
    apb_write(REG_INVALID_LIMIT, 32'(lim));
    apb_write(REG_HB_PERIOD, 32'(per));
    apb_write(REG_IDLE_TIMEOUT, 32'(tmo));
  endtask

  // Move to configuration k once the block is idle
  task automatic apply_setting(int unsigned k);
    drain();
    case (k)
      0: write_all(8'd3, 16'd1000, 16'd5000);
      1: write_all(8'd255, 16'd65535, 16'd65535);
      2: write_all(8'd0, 16'd1, 16'd1);
      3: write_all(8'($urandom_range(8, 1)), 16'($urandom_range(3000, 100)),
                   16'($urandom_range(20000, 1000)));
      4: write_all(8'd1, 16'd7, 16'd20);
      5: write_all(8'($urandom), 16'($urandom_range(65535, 1)),
                   16'($urandom_range(65535, 1)));
      6: write_all(8'd2, 16'd250, 16'd600);
      7: write_all(8'd4, 16'd65535, 16'd1);
      default: write_all(8'd3, 16'd1, 16'd65535);
    endcase
    // start near the wrap for the widest setting, elsewhere anywhere
    clock_ms = (k == 1) ? 32'hFFFE_C000 : $urandom;
  endtask

  initial begin
    sb = new();
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    item_if.valid          = 1'b0;
    item_if.action         = ACT_TICK;
    item_if.time_ms        = '0;
    item_if.packet_kind    = KIND_START;
    item_if.payload_length = '0;
    item_if.invalid_run    = '0;
    res_if.ready           = 1'b0;
    clock_ms               = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle commands, a session with heartbeat and timeout, error, wrap
    tx_idle_pct = 37;
    rx_idle_pct = 52;
    send_item(tick_at(32'd0));
    send_item(packet(KIND_PING, 8'd0));
    send_item(packet(KIND_PING, 8'd255));
    send_item(packet(KIND_PING, 8'd33));
    send_item(packet(3'(KIND_RESET) + 3'd4, 8'($urandom)));
    send_item(packet(KIND_STOP, 8'($urandom)));
    send_item(packet(KIND_RESET, 8'($urandom)));
    send_item(make_item(ACT_NONE, $urandom, 3'($urandom), 8'($urandom), 8'($urandom)));
    send_item(tick_at(32'd100));
    send_item(packet(KIND_START, 8'($urandom)));
    send_item(packet(KIND_START, 8'($urandom)));
    send_item(tick_at(32'd1100));
    send_item(packet(KIND_PING, 8'd32));
    send_item(tick_at(32'd7000));
    send_item(packet(KIND_START, 8'($urandom)));
    send_item(invalid_report(8'd2));
    send_item(invalid_report(8'd3));
    send_item(packet(KIND_START, 8'($urandom)));
    send_item(packet(KIND_PING, 8'd5));
    send_item(invalid_report(8'd255));
    send_item(packet(KIND_RESET, 8'($urandom)));
    send_item(tick_at(32'hFFFF_FF00));
    send_item(packet(KIND_START, 8'($urandom)));
    send_item(tick_at(32'h0000_0300));

    // Zero limit, period and timeout
    drain();
    write_all(8'd0, 16'd0, 16'd0);
    send_item(invalid_report(8'd0));
    send_item(packet(KIND_RESET, 8'($urandom)));
    send_item(packet(KIND_START, 8'($urandom)));
    send_item(tick_at(32'h0000_0300));

    // Random traffic in three idling phases, three settings each
    for (int unsigned phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 52 : 0;
      rx_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 37 : 0;
      for (int unsigned seg = 0; seg < 3; seg++) begin
        apply_setting(phase * 3 + seg);
        repeat (ITEMS_PER_SETTING) send_item(random_item());
      end
    end

    drain();
    if (sb.fail_count == 0 && sb.expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lss_pkg.sv
rtl/core/lss_if.sv
rtl/core/lss_cfg_regs.sv
rtl/core/lss_ms_round.sv
rtl/core/lss_step.sv
rtl/core/link_session_supervisor_core.sv
sim/tb_link_session_supervisor_core.sv
